// File: hdl/ccrc_pkg.sv
// Package for the configurable CRC engine: register indexes, reset values,
// the configuration record type and small width helpers.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package ccrc_pkg;

    localparam int unsigned CRC_MAX_W = 32;
    localparam int unsigned DATA_W    = 8;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CW_W      = 6;

    localparam logic [CFG_IDX_W-1:0] REG_CRC_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POLY        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_VALUE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_XOR  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REFLECT_IN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REFLECT_OUT = 3'd5;

    localparam logic [CW_W-1:0]      RST_CRC_WIDTH   = 6'd16;
    localparam logic [CRC_MAX_W-1:0] RST_POLY        = 32'h0000_1021;
    localparam logic [CRC_MAX_W-1:0] RST_START_VALUE = 32'h0000_0000;
    localparam logic [CRC_MAX_W-1:0] RST_OUTPUT_XOR  = 32'h0000_0000;

    localparam logic [CW_W-1:0]      MIN_W    = 6'd8;
    localparam logic [CW_W-1:0]      MAX_W    = 6'd32;
    localparam logic [CRC_MAX_W-1:0] ALL_ONES = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [CW_W-1:0]      crc_width;
        logic [CRC_MAX_W-1:0] generator_poly;
        logic [CRC_MAX_W-1:0] start_value;
        logic [CRC_MAX_W-1:0] output_xor;
        logic                 reflect_in;
        logic                 reflect_out;
    } ccrc_cfg_t;

    // A width below eight acts as eight and one above 32 acts as 32.
    function automatic logic [CW_W-1:0] eff_width(input logic [CW_W-1:0] cw);
        logic [CW_W-1:0] w;
        w = cw;
        if (cw < MIN_W)
        begin
            w = MIN_W;
        end
        else if (cw > MAX_W)
        begin
            w = MAX_W;
        end
        return w;
    endfunction

    function automatic logic [CRC_MAX_W-1:0] width_mask(input logic [CW_W-1:0] w);
        return ALL_ONES >> (MAX_W - w);
    endfunction

endpackage

// File: hdl/ccrc_regs.sv
// Configuration register file of the CRC engine, written through a plain
// write port. Depends on ccrc_pkg for indexes, reset values and the record type.
`timescale 1ns / 1ps

module ccrc_regs
    import ccrc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CRC_MAX_W-1:0] cfg_wdata,
    output ccrc_cfg_t            cfg
);

    ccrc_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.crc_width      <= RST_CRC_WIDTH;
            cfg_reg.generator_poly <= RST_POLY;
            cfg_reg.start_value    <= RST_START_VALUE;
            cfg_reg.output_xor     <= RST_OUTPUT_XOR;
            cfg_reg.reflect_in     <= 1'b0;
            cfg_reg.reflect_out    <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_CRC_WIDTH:   cfg_reg.crc_width      <= cfg_wdata[CW_W-1:0];
                REG_POLY:        cfg_reg.generator_poly <= cfg_wdata;
                REG_START_VALUE: cfg_reg.start_value    <= cfg_wdata;
                REG_OUTPUT_XOR:  cfg_reg.output_xor     <= cfg_wdata;
                REG_REFLECT_IN:  cfg_reg.reflect_in     <= cfg_wdata[0];
                REG_REFLECT_OUT: cfg_reg.reflect_out    <= cfg_wdata[0];
                default:         ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: hdl/ccrc_fold.sv
// Combinational fold of one message byte into the running remainder, eight
// shift-and-XOR steps MSB first, plus the finishing reflect, XOR and mask.
// Depends on ccrc_pkg for the configuration record and width helpers.
`timescale 1ns / 1ps

module ccrc_fold
    import ccrc_pkg::*;
(
    input  ccrc_cfg_t            cfg,
    input  logic                 idle,
    input  logic [CRC_MAX_W-1:0] remainder,
    input  logic [DATA_W-1:0]    data_byte,
    output logic [CRC_MAX_W-1:0] rem_next,
    output logic [CRC_MAX_W-1:0] crc_value
);

    logic [CW_W-1:0]      w;
    logic [CW_W-1:0]      wm1;
    logic [CRC_MAX_W-1:0] mask;
    logic [CRC_MAX_W-1:0] poly;
    logic [DATA_W-1:0]    b;
    logic [CRC_MAX_W-1:0] r;
    logic [CRC_MAX_W-1:0] rev;
    logic [CRC_MAX_W-1:0] v;
    logic                 top;

    always_comb
    begin
        w    = eff_width(cfg.crc_width);
        wm1  = w - 6'd1;
        mask = width_mask(w);
        poly = cfg.generator_poly & mask;

        for (int i = 0; i < DATA_W; i++)
        begin
            b[i] = cfg.reflect_in ? data_byte[DATA_W-1-i] : data_byte[i];
        end

        r = (idle ? cfg.start_value : remainder) & mask;
        r = r ^ ({{(CRC_MAX_W-DATA_W){1'b0}}, b} << (w - MIN_W));
        for (int s = 0; s < DATA_W; s++)
        begin
            top = r[wm1[4:0]];
            r   = (r << 1) & mask;
            if (top)
            begin
                r = r ^ poly;
            end
        end

        for (int i = 0; i < CRC_MAX_W; i++)
        begin
            rev[i] = r[CRC_MAX_W-1-i];
        end
        v = cfg.reflect_out ? (rev >> (MAX_W - w)) : r;

        rem_next  = r;
        crc_value = (v ^ cfg.output_xor) & mask;
    end

endmodule

// File: hdl/configurable_crc_engine.sv
// Top level of the configurable CRC engine: input register, byte fold and
// result register. Depends on ccrc_pkg, ccrc_regs and ccrc_fold.
//
// Usage: message bytes arrive on the input channel (in_valid, in_stall,
// data_byte, last_byte), one byte per item. Each byte is folded into the
// running remainder; the byte flagged last_byte produces one result item
// on the output channel (out_valid, out_stall, crc_value) and the next
// message starts again from start_value.
// Configuration is written through cfg_we, cfg_addr and cfg_wdata while
// no message is in flight; unknown indexes are ignored.
// A last byte goes from the input register into the result register, which
// shows its CRC. The eight-step fold from the input register into the remainder
// allows one byte per cycle unless a last byte waits on a stalled result.
// Reset restores CRC-16/XMODEM settings and empties both registers.
// When the receiver stalls, the result is held; the input register can
// still take and fold bytes that are not last, and the input stalls only
// while it holds a last byte whose result cannot yet be delivered.
`timescale 1ns / 1ps

module configurable_crc_engine
    import ccrc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CRC_MAX_W-1:0] cfg_wdata,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [DATA_W-1:0]    data_byte,
    input  logic                 last_byte,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [CRC_MAX_W-1:0] crc_value
);

    ccrc_cfg_t            cfg;
    logic                 s1_valid_reg;
    logic                 s1_last_reg;
    logic [DATA_W-1:0]    s1_byte_reg;
    logic                 idle_reg;
    logic [CRC_MAX_W-1:0] rem_reg;
    logic [CRC_MAX_W-1:0] rem_next;
    logic                 out_valid_reg;
    logic [CRC_MAX_W-1:0] crc_reg;
    logic [CRC_MAX_W-1:0] crc_next;
    logic                 out_free;
    logic                 s1_move;
    logic                 in_take;

    ccrc_regs u_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    ccrc_fold u_fold
    (
        .cfg       (cfg),
        .idle      (idle_reg),
        .remainder (rem_reg),
        .data_byte (s1_byte_reg),
        .rem_next  (rem_next),
        .crc_value (crc_next)
    );

    assign out_free = !out_valid_reg || !out_stall;
    assign s1_move  = s1_valid_reg && (!s1_last_reg || out_free);
    assign in_stall = s1_valid_reg && !s1_move;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s1_last_reg   <= 1'b0;
            idle_reg      <= 1'b1;
            rem_reg       <= RST_START_VALUE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                s1_valid_reg <= 1'b1;
                s1_last_reg  <= last_byte;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_move)
            begin
                rem_reg  <= rem_next;
                idle_reg <= s1_last_reg;
            end

            if (s1_move && s1_last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_byte_reg <= data_byte;
        end
        if (s1_move && s1_last_reg)
        begin
            crc_reg <= crc_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign crc_value = crc_reg;

endmodule

// File: hdl/ccrc_checker.sv
// Port-level checker for the configurable CRC engine, bound to the top level.
// Depends on ccrc_pkg for widths and on the top level's port names.
`timescale 1ns / 1ps

module ccrc_checker
    import ccrc_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_stall,
    input logic                 out_valid,
    input logic                 out_stall,
    input logic [CRC_MAX_W-1:0] crc_value
);

    // A result that is not taken stays offered unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(crc_value))
        else $error("result item changed or dropped while stalled");

    // The input is held back only by a full, stalled result register.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled while the result register could move");

    // While the input is stalled nothing inside moves, so the stall follows
    // the receiver's stall in the next cycle.
    a_stall_follow: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> out_valid && (in_stall == out_stall))
        else $error("input stall did not track the held result");

endmodule

bind configurable_crc_engine ccrc_checker u_checker (.*);
